>>> rtl/tcce_pkg.sv
// Shared types and constants for the text console character engine.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int CELL_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS         = 8'd8;
    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] CH_FF         = 8'd12;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_BLANK      = 8'd32;
    localparam logic [7:0] CH_FIRST_HIGH = 8'd127;

    typedef struct packed {
        logic       action;
        logic [7:0] character;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } tcce_item_t;

    typedef struct packed {
        logic [4:0]        cursor_row;
        logic [6:0]        cursor_col;
        logic [10:0]       cursor_position;
        logic [CELL_W-1:0] cell_data;
    } tcce_result_t;

    typedef enum logic [2:0] {
        CLS_READ,
        CLS_HOLD,
        CLS_EDIT,
        CLS_LF,
        CLS_FF,
        CLS_PRINT
    } tcce_cls_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ,
        MEM_PUT,
        MEM_BLANK,
        MEM_MOVE
    } tcce_mem_op_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_MOVE_START,
        PTR_BLANK_START,
        PTR_INC
    } tcce_ptr_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_EDIT,
        CUR_NEWLINE,
        CUR_ADVANCE,
        CUR_HOME,
        CUR_COL_ZERO
    } tcce_cur_op_t;

    typedef struct packed {
        logic         load;
        tcce_mem_op_t mem_op;
        tcce_ptr_op_t ptr_op;
        tcce_cur_op_t cur_op;
        logic         out_load;
    } tcce_cmd_t;

    typedef struct packed {
        tcce_cls_t cls;
        logic      col_last;
        logic      row_last;
        logic      sweep_end;
        logic      out_free;
    } tcce_status_t;

endpackage

>>> rtl/tcce_ctrl.sv
// Controller state machine of the text console character engine.
`timescale 1ns / 1ps

module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  tcce_status_t status,
    output tcce_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_MOVE,
        S_DRAIN,
        S_BLANK,
        S_PUT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   print_pend_reg, print_pend_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        print_pend_next = print_pend_reg;
        cmd             = '{load: 1'b0, mem_op: MEM_NONE, ptr_op: PTR_HOLD,
                            cur_op: CUR_HOLD, out_load: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESULT;
                case (status.cls)
                    CLS_READ:
                    begin
                        cmd.mem_op = MEM_READ;
                    end
                    CLS_EDIT:
                    begin
                        cmd.cur_op = CUR_EDIT;
                    end
                    CLS_LF:
                    begin
                        if (status.row_last)
                        begin
                            cmd.cur_op      = CUR_COL_ZERO;
                            cmd.ptr_op      = PTR_MOVE_START;
                            print_pend_next = 1'b0;
                            state_next      = S_MOVE;
                        end
                        else
                        begin
                            cmd.cur_op = CUR_NEWLINE;
                        end
                    end
                    CLS_FF:
                    begin
                        cmd.cur_op = CUR_HOME;
                        cmd.ptr_op = PTR_ZERO;
                        state_next = S_CLEAR;
                    end
                    CLS_PRINT:
                    begin
                        if (!status.col_last)
                        begin
                            cmd.mem_op = MEM_PUT;
                            cmd.cur_op = CUR_ADVANCE;
                        end
                        else if (!status.row_last)
                        begin
                            cmd.mem_op = MEM_PUT;
                            cmd.cur_op = CUR_NEWLINE;
                        end
                        else
                        begin
                            cmd.cur_op      = CUR_COL_ZERO;
                            cmd.ptr_op      = PTR_MOVE_START;
                            print_pend_next = 1'b1;
                            state_next      = S_MOVE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CLEAR:
            begin
                cmd.mem_op = MEM_BLANK;
                cmd.ptr_op = PTR_INC;
                if (status.sweep_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_MOVE:
            begin
                cmd.mem_op = MEM_MOVE;
                cmd.ptr_op = PTR_INC;
                if (status.sweep_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last moved cell is written back in this cycle
                cmd.ptr_op = PTR_BLANK_START;
                state_next = S_BLANK;
            end
            S_BLANK:
            begin
                cmd.mem_op = MEM_BLANK;
                cmd.ptr_op = PTR_INC;
                if (status.sweep_end)
                begin
                    state_next = print_pend_reg ? S_PUT : S_RESULT;
                end
            end
            S_PUT:
            begin
                cmd.mem_op = MEM_PUT;
                cmd.cur_op = CUR_ADVANCE;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            print_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            print_pend_reg <= print_pend_next;
        end
    end

endmodule

>>> rtl/tcce_datapath.sv
// Datapath of the text console character engine: screen memory, cursor, attribute, result.
`timescale 1ns / 1ps

module tcce_datapath
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcce_item_t            item,
    input  tcce_cmd_t             cmd,
    output tcce_status_t          status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output tcce_result_t          result,
    input  logic                  cfg_write_enable,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]    LAST_COL_X  = (COL_W + 1)'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  HOME_ROW    = ROW_W'(1);
    localparam logic [ADDR_W-1:0] MOVE_START  = ADDR_W'(2 * COLUMNS);
    localparam logic [ADDR_W-1:0] BLANK_START = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] SWEEP_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    tcce_item_t        item_reg, item_next;
    tcce_result_t      result_reg, result_next;
    logic              result_valid_reg, result_valid_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              move_pend_reg, move_pend_next;
    logic [ADDR_W-1:0] mv_waddr_reg, mv_waddr_next;
    logic [3:0]        fg_reg, fg_next;
    logic [2:0]        bg_reg, bg_next;
    logic              blink_reg, blink_next;

    logic [7:0]        attr;
    logic              read_in_range;
    logic [31:0]       item_lin;
    logic [31:0]       cur_lin;
    logic [31:0]       row_wide;
    logic [31:0]       col_wide;
    logic [ADDR_W-1:0] item_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [COL_W:0]    tab_sum;
    logic [COL_W-1:0]  tab_col;
    tcce_cls_t         cls;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    assign attr          = {blink_reg, bg_reg, fg_reg};
    assign read_in_range = (32'(item_reg.read_row) < 32'(ROWS))
                        && (32'(item_reg.read_col) < 32'(COLUMNS));
    assign item_lin      = 32'(item_reg.read_row) * 32'(COLUMNS) + 32'(item_reg.read_col);
    assign item_addr     = item_lin[ADDR_W-1:0];
    assign cur_lin       = 32'(cur_row_reg) * 32'(COLUMNS) + 32'(cur_col_reg);
    assign cur_addr      = cur_lin[ADDR_W-1:0];
    assign row_wide      = 32'(cur_row_reg);
    assign col_wide      = 32'(cur_col_reg);
    assign tab_sum       = {1'b0, cur_col_reg | COL_W'(7)} + (COL_W + 1)'(1);
    assign tab_col       = (tab_sum > LAST_COL_X) ? LAST_COL : tab_sum[COL_W-1:0];

    // item classification
    always_comb
    begin
        if (item_reg.action)
        begin
            cls = read_in_range ? CLS_READ : CLS_HOLD;
        end
        else if (item_reg.character >= CH_FIRST_HIGH)
        begin
            cls = CLS_HOLD;
        end
        else
        begin
            case (item_reg.character)
                CH_BS, CH_TAB, CH_CR: cls = CLS_EDIT;
                CH_LF:                cls = CLS_LF;
                CH_FF:                cls = CLS_FF;
                default:              cls = CLS_PRINT;
            endcase
        end
    end

    assign status.cls       = cls;
    assign status.col_last  = (cur_col_reg == LAST_COL);
    assign status.row_last  = (cur_row_reg == LAST_ROW);
    assign status.sweep_end = (ptr_reg == SWEEP_LAST);
    assign status.out_free  = !result_valid_reg || !result_stall;

    // memory port control; a pending scroll write takes the write port
    always_comb
    begin
        mem_we    = move_pend_reg || (cmd.mem_op == MEM_PUT) || (cmd.mem_op == MEM_BLANK);
        mem_re    = (cmd.mem_op == MEM_READ) || (cmd.mem_op == MEM_MOVE);
        mem_raddr = (cmd.mem_op == MEM_READ) ? item_addr : ptr_reg;
        if (move_pend_reg)
        begin
            mem_waddr = mv_waddr_reg;
            mem_wdata = rd_data_reg;
        end
        else if (cmd.mem_op == MEM_PUT)
        begin
            mem_waddr = cur_addr;
            mem_wdata = {attr, item_reg.character};
        end
        else
        begin
            mem_waddr = ptr_reg;
            mem_wdata = {attr, CH_BLANK};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    always_comb
    begin
        item_next         = cmd.load ? item : item_reg;
        move_pend_next    = (cmd.mem_op == MEM_MOVE);
        mv_waddr_next     = ptr_reg - ROW_STRIDE;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        ptr_next          = ptr_reg;
        fg_next           = fg_reg;
        bg_next           = bg_reg;
        blink_next        = blink_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (cmd.cur_op)
            CUR_EDIT:
            begin
                case (item_reg.character)
                    CH_BS:
                    begin
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - COL_W'(1);
                        end
                    end
                    CH_TAB:  cur_col_next = tab_col;
                    CH_CR:   cur_col_next = '0;
                    default: cur_col_next = cur_col_reg;
                endcase
            end
            CUR_NEWLINE:
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
                cur_col_next = '0;
            end
            CUR_ADVANCE:  cur_col_next = cur_col_reg + COL_W'(1);
            CUR_HOME:
            begin
                cur_row_next = HOME_ROW;
                cur_col_next = '0;
            end
            CUR_COL_ZERO: cur_col_next = '0;
            default:      cur_col_next = cur_col_reg;
        endcase

        case (cmd.ptr_op)
            PTR_ZERO:        ptr_next = '0;
            PTR_MOVE_START:  ptr_next = MOVE_START;
            PTR_BLANK_START: ptr_next = BLANK_START;
            PTR_INC:         ptr_next = ptr_reg + ADDR_W'(1);
            default:         ptr_next = ptr_reg;
        endcase

        if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_FOREGROUND: fg_next    = cfg_data[3:0];
                REG_BACKGROUND: bg_next    = cfg_data[2:0];
                REG_BLINK:      blink_next = cfg_data[0];
                default:        fg_next    = fg_reg;
            endcase
        end

        if (cmd.out_load)
        begin
            result_valid_next           = 1'b1;
            result_next.cursor_row      = row_wide[4:0];
            result_next.cursor_col      = col_wide[6:0];
            result_next.cursor_position = cur_lin[10:0];
            result_next.cell_data       = (item_reg.action && read_in_range) ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
            cur_row_reg      <= HOME_ROW;
            cur_col_reg      <= '0;
            ptr_reg          <= '0;
            move_pend_reg    <= 1'b0;
            mv_waddr_reg     <= '0;
            fg_reg           <= 4'd15;
            bg_reg           <= 3'd0;
            blink_reg        <= 1'b0;
        end
        else
        begin
            item_reg         <= item_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            ptr_reg          <= ptr_next;
            move_pend_reg    <= move_pend_next;
            mv_waddr_reg     <= mv_waddr_next;
            fg_reg           <= fg_next;
            bg_reg           <= bg_next;
            blink_reg        <= blink_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // row 0 is a fixed line and never holds the cursor
    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg != '0) && (32'(cur_row_reg) < 32'(ROWS)))
        else $error("cursor row out of range");

    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) < 32'(COLUMNS))
        else $error("cursor column out of range");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        move_pend_reg |-> !((cmd.mem_op == MEM_PUT) || (cmd.mem_op == MEM_BLANK)))
        else $error("scroll write collides with another write");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid_reg || !result_stall))
        else $error("result overwritten while held");

    a_move_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_op == MEM_MOVE) |=> move_pend_reg && (mv_waddr_reg == $past(ptr_reg) - ROW_STRIDE))
        else $error("scroll write-back lost");
`endif

endmodule

>>> rtl/text_console_character_engine_unit.sv
// Top level of the text console character engine.
`timescale 1ns / 1ps

// A text console of COLUMNS by ROWS cells of 16 bits (attribute high byte, character low
// byte) with a cursor. Each request either handles one character code or reads back one
// cell, and gives exactly one result with the cursor after the request. One request is
// worked on at a time; the next is taken once the result has moved to the output register.
// Form feed blanks every cell; a scroll moves rows 2 to ROWS-1 up by one row and blanks
// the last row, then puts the printed byte when a print caused it. Both write one cell per
// cycle through the single write port of the screen memory. The screen holds no defined
// contents after reset; a cell reads back what was last written to it. Color and blink
// registers are to be written by the user only while no request is in progress; the block
// itself does not enforce it.
module text_console_character_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  tcce_item_t            item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output tcce_result_t          result,
    input  logic                  cfg_write_enable,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tcce_cmd_t    cmd;
    tcce_status_t status;

    tcce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .item             (item),
        .cmd              (cmd),
        .status           (status),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule
